// File: rtl/hlc_pkg.sv
package hlc_pkg;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_RECEIVE   = 3'd1;
    localparam logic [2:0] OP_WM_UPDATE = 3'd2;
    localparam logic [2:0] OP_WM_READ   = 3'd3;
    localparam logic [2:0] OP_GLOBAL_MIN = 3'd4;
    localparam logic [2:0] OP_CHECK_CLOCK = 3'd5;
    localparam logic [2:0] OP_CHECK_PAIR = 3'd6;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] physical_time;
        logic [63:0] stamp_wall;
        logic [31:0] stamp_logical;
        logic [3:0]  partition;
        logic [63:0] watermark;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_value;
        logic [31:0] result_logical;
        logic        satisfied;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan;
        logic exec;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_ctl_sts;

endpackage

// File: rtl/hlc_ram.sv
module hlc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/hlc_ctrl.sv
module hlc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [2:0]      i_op,
    input  hlc_pkg::t_ctl_sts i_sts,
    output logic            o_in_ready,
    output hlc_pkg::t_ctl_cmd o_cmd
);
    import hlc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_op == OP_GLOBAL_MIN) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/hlc_dpath.sv
module hlc_dpath #(
    parameter int PARTITIONS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hlc_pkg::t_in_item i_in_data,
    input  hlc_pkg::t_ctl_cmd i_cmd,
    output hlc_pkg::t_ctl_sts o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hlc_pkg::t_out_item o_out_data
);
    import hlc_pkg::*;

    localparam int AW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

    t_in_item        r_in;
    logic [63:0]     r_clock_wall;
    logic [31:0]     r_clock_logical;
    logic            r_check_ok;
    logic [PARTITIONS-1:0] r_present;
    logic [AW-1:0]   r_idx;
    logic [63:0]     r_min;
    logic            r_any;
    logic            r_out_valid;
    t_out_item       r_out;

    logic [63:0]     n_clock_wall;
    logic [31:0]     n_clock_logical;
    logic            n_check_ok;
    logic            n_emit;
    t_out_item       n_out;

    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   part_addr;
    logic [63:0]     rd_data;
    logic            wr_en;
    logic            part_ok;
    logic            present_hit;
    logic            scan_done;
    logic            tick_adv;
    logic [63:0]     tick_wall;
    logic [31:0]     tick_logical;
    logic [31:0]     rcv_max;
    logic            verdict;

    assign part_addr = AW'(r_in.partition);
    assign part_ok   = 32'(r_in.partition) < PARTITIONS;
    assign present_hit = part_ok && r_present[part_addr];
    assign scan_done = r_idx == AW'(PARTITIONS - 1);

    always_comb begin
        if (i_cmd.accept) begin
            rd_addr = (i_in_data.op == OP_GLOBAL_MIN) ? '0 : AW'(i_in_data.partition);
        end else if (i_cmd.scan) begin
            rd_addr = scan_done ? r_idx : AW'(r_idx + 1'b1);
        end else begin
            rd_addr = part_addr;
        end
    end

    hlc_ram #(
        .WIDTH(64),
        .DEPTH(PARTITIONS)
    ) u_wm_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (part_addr),
        .i_wr_data (r_in.watermark),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // tick and receive rules
    always_comb begin
        tick_adv     = r_in.physical_time > r_clock_wall;
        tick_wall    = tick_adv ? r_in.physical_time : r_clock_wall;
        tick_logical = tick_adv ? '0 : r_clock_logical + 32'd1;
        rcv_max      = (r_in.stamp_logical > r_clock_logical) ? r_in.stamp_logical
                                                              : r_clock_logical;
    end

    always_comb begin
        n_clock_wall    = r_clock_wall;
        n_clock_logical = r_clock_logical;
        n_check_ok      = r_check_ok;
        n_emit          = 1'b0;
        n_out           = '0;
        wr_en           = 1'b0;
        verdict         = r_check_ok;
        case (r_in.op)
            OP_TICK: begin
                n_clock_wall         = tick_wall;
                n_clock_logical      = tick_logical;
                n_emit               = 1'b1;
                n_out.result_value   = tick_wall;
                n_out.result_logical = tick_logical;
            end
            OP_RECEIVE: begin
                if (r_in.stamp_wall > r_clock_wall) begin
                    n_clock_wall    = r_in.stamp_wall;
                    n_clock_logical = r_in.stamp_logical + 32'd1;
                end else if (r_in.stamp_wall == r_clock_wall) begin
                    n_clock_logical = rcv_max + 32'd1;
                end else begin
                    n_clock_logical = r_clock_logical + 32'd1;
                end
            end
            OP_WM_UPDATE: begin
                wr_en = part_ok && (!r_present[part_addr] || r_in.watermark > rd_data);
            end
            OP_WM_READ: begin
                n_emit             = 1'b1;
                n_out.result_value = present_hit ? rd_data : '0;
            end
            OP_GLOBAL_MIN: begin
                n_emit             = 1'b1;
                n_out.result_value = r_any ? r_min : '0;
            end
            OP_CHECK_CLOCK: begin
                n_clock_wall    = tick_wall;
                n_clock_logical = tick_logical;
                verdict = !(r_in.stamp_wall > tick_wall ||
                            (r_in.stamp_wall == tick_wall &&
                             r_in.stamp_logical > tick_logical));
            end
            OP_CHECK_PAIR: begin
                verdict = r_check_ok && present_hit && !(rd_data < r_in.watermark);
            end
            default: begin
                verdict = r_check_ok;
            end
        endcase
        if (r_in.op == OP_CHECK_CLOCK || r_in.op == OP_CHECK_PAIR) begin
            if (r_in.last) begin
                n_emit          = 1'b1;
                n_out.satisfied = verdict;
                n_check_ok      = 1'b1;
            end else begin
                n_check_ok = verdict;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_wall    <= '0;
            r_clock_logical <= '0;
            r_check_ok      <= 1'b1;
            r_present       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_clock_wall    <= n_clock_wall;
                r_clock_logical <= n_clock_logical;
                r_check_ok      <= n_check_ok;
                if (r_in.op == OP_WM_UPDATE && part_ok) begin
                    r_present[part_addr] <= 1'b1;
                end
            end
            if (i_cmd.exec && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in  <= i_in_data;
            r_idx <= '0;
            r_any <= 1'b0;
            r_min <= '1;
        end
        if (i_cmd.scan) begin
            r_idx <= AW'(r_idx + 1'b1);
            if (r_present[r_idx] && (!r_any || rd_data < r_min)) begin
                r_min <= rd_data;
                r_any <= 1'b1;
            end
        end
        if (i_cmd.exec && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_sts.scan_done = scan_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

// File: rtl/hlc_watermark_tracker.sv
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_data  (hlc_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready  o_out_data (hlc_pkg::t_out_item)
//
// an item is accepted while the watermark ram read is issued, and is then executed
// global minimum first scans the table before it executes, one ram read per table entry
// reset clears the clock and the presence bits and sets the check flag; no clearing pass
// execution waits while an earlier result is still held in the output register
module hlc_watermark_tracker #(
    parameter int PARTITIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hlc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hlc_pkg::t_out_item o_out_data
);
    import hlc_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    hlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    hlc_dpath #(
        .PARTITIONS(PARTITIONS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: tb/hlc_tracker_checker.sv
`timescale 1ns / 1ps

module hlc_tracker_checker #(
    parameter int PARTITIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  hlc_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  hlc_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import hlc_pkg::*;

    logic [63:0] wall_q;
    logic [31:0] lcount_q;
    logic [63:0] wm_tab [PARTITIONS];
    logic        wm_seen [PARTITIONS];
    logic        verdict_q;
    t_out_item   owed_q [$];
    t_out_item   want;
    int          errors = 0;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic tick_clock(input logic [63:0] now);
        if (now > wall_q) begin
            wall_q   = now;
            lcount_q = '0;
        end else begin
            lcount_q = lcount_q + 32'd1;
        end
    endtask

    task automatic track_item(input t_in_item it);
        t_out_item   res;
        logic        emit;
        logic        any;
        logic [63:0] low;
        logic [31:0] top;
        int          part;
        res  = '0;
        emit = 1'b0;
        part = int'(it.partition);
        case (it.op)
            OP_TICK: begin
                tick_clock(it.physical_time);
                res.result_value   = wall_q;
                res.result_logical = lcount_q;
                emit = 1'b1;
            end
            OP_RECEIVE: begin
                if (it.stamp_wall > wall_q) begin
                    wall_q   = it.stamp_wall;
                    lcount_q = it.stamp_logical + 32'd1;
                end else if (it.stamp_wall == wall_q) begin
                    top      = (it.stamp_logical > lcount_q) ? it.stamp_logical : lcount_q;
                    lcount_q = top + 32'd1;
                end else begin
                    lcount_q = lcount_q + 32'd1;
                end
            end
            OP_WM_UPDATE: begin
                if (part < PARTITIONS) begin
                    if (!wm_seen[part]) begin
                        wm_seen[part] = 1'b1;
                        wm_tab[part]  = it.watermark;
                    end else if (it.watermark > wm_tab[part]) begin
                        wm_tab[part] = it.watermark;
                    end
                end
            end
            OP_WM_READ: begin
                if (part < PARTITIONS && wm_seen[part])
                    res.result_value = wm_tab[part];
                emit = 1'b1;
            end
            OP_GLOBAL_MIN: begin
                any = 1'b0;
                low = '1;
                for (int k = 0; k < PARTITIONS; k++) begin
                    if (wm_seen[k]) begin
                        any = 1'b1;
                        if (wm_tab[k] < low)
                            low = wm_tab[k];
                    end
                end
                res.result_value = any ? low : 64'd0;
                emit = 1'b1;
            end
            OP_CHECK_CLOCK: begin
                tick_clock(it.physical_time);
                verdict_q = !(it.stamp_wall > wall_q ||
                              (it.stamp_wall == wall_q && it.stamp_logical > lcount_q));
            end
            OP_CHECK_PAIR: begin
                if (part >= PARTITIONS || !wm_seen[part] || wm_tab[part] < it.watermark)
                    verdict_q = 1'b0;
            end
            default: ;
        endcase
        if ((it.op == OP_CHECK_CLOCK || it.op == OP_CHECK_PAIR) && it.last) begin
            res.satisfied = verdict_q;
            verdict_q     = 1'b1;
            emit          = 1'b1;
        end
        if (emit)
            owed_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wall_q    = '0;
            lcount_q  = '0;
            verdict_q = 1'b1;
            for (int k = 0; k < PARTITIONS; k++) begin
                wm_tab[k]  = '0;
                wm_seen[k] = 1'b0;
            end
            owed_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing owed", i_out_data));
                end else begin
                    want = owed_q.pop_front();
                    if (i_out_data.result_value !== want.result_value)
                        report_mismatch($sformatf("result_value got %h want %h",
                                                  i_out_data.result_value, want.result_value));
                    if (i_out_data.result_logical !== want.result_logical)
                        report_mismatch($sformatf("result_logical got %h want %h",
                                                  i_out_data.result_logical,
                                                  want.result_logical));
                    if (i_out_data.satisfied !== want.satisfied)
                        report_mismatch($sformatf("satisfied got %b want %b",
                                                  i_out_data.satisfied, want.satisfied));
                end
            end
            if (i_in_valid && i_in_ready)
                track_item(i_in_data);
        end
        o_fail_count <= errors;
        o_pending    <= owed_q.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hlc_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int PARTITIONS = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int          fail_count;
    int          pending;
    int          in_idle_pct = 7;
    int          out_idle_pct = 62;
    int          items_sent = 0;
    int          cycles = 0;
    logic [63:0] time_base = 64'd1000;

    hlc_watermark_tracker #(
        .PARTITIONS(PARTITIONS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    hlc_tracker_checker #(
        .PARTITIONS(PARTITIONS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL hlc_watermark_tracker");
            $finish;
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item item_of(input logic [2:0] op, input logic [63:0] pt,
                                         input logic [63:0] sw, input logic [31:0] sl,
                                         input logic [3:0] part, input logic [63:0] wm,
                                         input logic last);
        t_in_item it;
        it.op            = op;
        it.physical_time = pt;
        it.stamp_wall    = sw;
        it.stamp_logical = sl;
        it.partition     = part;
        it.watermark     = wm;
        it.last          = last;
        return it;
    endfunction

    // unused fields carry random bits
    function automatic t_in_item filler(input logic [2:0] op);
        return item_of(op, rnd64(), rnd64(), $urandom, 4'($urandom), rnd64(), 1'($urandom));
    endfunction

    function automatic logic [63:0] next_wall();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                time_base += 64'($urandom_range(1, 3));
                return time_base;
            end
            5, 6, 7: return time_base;
            8:       return time_base - 64'($urandom_range(1, 20));
            default: return time_base + 64'd1;
        endcase
    endfunction

    function automatic logic [31:0] pick_logical();
        case ($urandom_range(9))
            6, 7:    return $urandom;
            8, 9:    return 32'hFFFF_FFFF - 32'($urandom_range(1));
            default: return 32'($urandom_range(0, 8));
        endcase
    endfunction

    function automatic logic [63:0] pick_mark();
        case ($urandom_range(9))
            7:       return rnd64();
            8:       return '1;
            9:       return '0;
            default: return 64'($urandom_range(0, 1000));
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        if ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < in_idle_pct)
                @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        if (it.op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_pairs(input int count);
        t_in_item it;
        for (int k = 0; k < count; k++) begin
            it           = filler(OP_CHECK_PAIR);
            it.watermark = pick_mark();
            it.last      = (k == count - 1);
            send_item(it);
        end
    endtask

    task automatic random_burst();
        t_in_item it;
        int       pairs;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            it = filler(OP_TICK);
            it.physical_time = next_wall();
            send_item(it);
        end else if (pick < 25) begin
            it = filler(OP_RECEIVE);
            it.stamp_wall    = next_wall();
            it.stamp_logical = pick_logical();
            send_item(it);
        end else if (pick < 45) begin
            it = filler(OP_WM_UPDATE);
            it.watermark = pick_mark();
            send_item(it);
        end else if (pick < 55) begin
            send_item(filler(OP_WM_READ));
        end else if (pick < 60) begin
            send_item(filler(OP_GLOBAL_MIN));
        end else if (pick < 90) begin
            // bookmark check: clock item then pairs
            pairs = $urandom_range(0, 4);
            it = filler(OP_CHECK_CLOCK);
            it.physical_time = next_wall();
            it.stamp_wall    = time_base + 64'($urandom_range(0, 2)) - 64'd1;
            it.stamp_logical = 32'($urandom_range(0, 6));
            it.last          = (pairs == 0);
            send_item(it);
            send_pairs(pairs);
        end else if (pick < 96) begin
            if ($urandom_range(1)) begin
                it = filler(OP_CHECK_CLOCK);
                it.physical_time = next_wall();
                it.stamp_wall    = time_base;
                it.last          = 1'b0;
                send_item(it);
            end else begin
                send_pairs($urandom_range(1, 3));
            end
        end else begin
            send_item(filler(OP_UNUSED));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(item_of(OP_GLOBAL_MIN, '0, '0, '0, 4'd0, '0, 1'b0));
        send_item(item_of(OP_WM_READ, '0, '0, '0, 4'd5, '0, 1'b0));
        send_item(item_of(OP_CHECK_PAIR, '0, '0, '0, 4'd3, '0, 1'b1));
        send_item(item_of(OP_CHECK_CLOCK, 64'd100, '0, '0, 4'd0, '0, 1'b1));
        send_item(item_of(OP_TICK, '0, '0, '0, 4'd0, '0, 1'b0));
        send_item(item_of(OP_TICK, 64'd200, '0, '0, 4'd0, '0, 1'b0));
        send_item(item_of(OP_RECEIVE, '0, 64'd200, 32'd5, 4'd0, '0, 1'b0));
        send_item(item_of(OP_RECEIVE, '0, 64'd50, 32'd9, 4'd0, '0, 1'b0));
        send_item(item_of(OP_RECEIVE, '0, 64'd300, '1, 4'd0, '0, 1'b0));
        send_item(item_of(OP_TICK, 64'd300, '0, '0, 4'd0, '0, 1'b0));
        send_item(item_of(OP_RECEIVE, '0, 64'd300, '1, 4'd0, '0, 1'b0));
        send_item(item_of(OP_TICK, '0, '0, '0, 4'd0, '0, 1'b1));
        send_item(item_of(OP_WM_UPDATE, '0, '0, '0, 4'd0, '1, 1'b0));
        send_item(item_of(OP_WM_UPDATE, '0, '0, '0, 4'd15, 64'd10, 1'b0));
        send_item(item_of(OP_WM_UPDATE, '0, '0, '0, 4'd15, 64'd5, 1'b0));
        send_item(item_of(OP_WM_UPDATE, '0, '0, '0, 4'd7, '0, 1'b0));
        send_item(item_of(OP_WM_READ, '0, '0, '0, 4'd15, '0, 1'b0));
        send_item(item_of(OP_WM_READ, '0, '0, '0, 4'd0, '0, 1'b0));
        send_item(item_of(OP_GLOBAL_MIN, '0, '0, '0, 4'd0, '0, 1'b0));
        send_item(item_of(OP_CHECK_CLOCK, '0, 64'd300, 32'd5, 4'd0, '0, 1'b0));
        send_item(item_of(OP_CHECK_PAIR, '0, '0, '0, 4'd15, 64'd10, 1'b1));
        send_item(item_of(OP_CHECK_CLOCK, '0, '1, '1, 4'd0, '0, 1'b1));
        send_item(item_of(OP_CHECK_CLOCK, '0, 64'd300, 32'd2, 4'd0, '0, 1'b0));
        send_item(item_of(OP_CHECK_PAIR, '0, '0, '0, 4'd15, 64'd10, 1'b0));
        send_item(item_of(OP_CHECK_PAIR, '0, '0, '0, 4'd0, '1, 1'b1));
        send_item(item_of(OP_UNUSED, '1, '1, '1, 4'd15, '1, 1'b1));

        while (items_sent < 190)
            random_burst();
        in_idle_pct  = 62;
        out_idle_pct = 7;
        while (items_sent < 360)
            random_burst();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        while (items_sent < 530)
            random_burst();
        in_valid <= 1'b0;

        do
            @(negedge i_clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS hlc_watermark_tracker");
        end else begin
            $display("FAIL hlc_watermark_tracker");
        end
        $finish;
    end

endmodule
